// ===== hdl/bsp_pkg.sv =====
// Shared types, constants and the channel frequency table for the band scan peak finder.
// No dependencies; every other file of the block but bsp_fifo imports this package.
`default_nettype none

package bsp_pkg;

  localparam int MV_W         = 12;   // millivolt sample and threshold width
  localparam int CH_W         = 3;    // channel index width
  localparam int FREQ_W       = 13;   // frequency width in MHz
  localparam int PCT_W        = 7;    // percent width
  localparam int PCT_FULL     = 100;  // full scale of the percent mapping
  localparam int NUM_W        = MV_W + PCT_W;  // (avg - low) * 100
  localparam int QUO_W        = MV_W; // quotient width of the shared divider
  localparam int CFG_IDX_W    = 1;
  localparam int QUEUE_DEPTH  = 2;

  localparam int SAMPLES_PER_READING_DEF = 8;
  localparam int CHANNEL_COUNT           = 8;

  localparam logic [MV_W-1:0] LEVEL_LOW_RST  = 12'd350;
  localparam logic [MV_W-1:0] LEVEL_HIGH_RST = 12'd1400;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HIGH = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AVG,
    ST_MAP,
    ST_EMIT
  } bsp_state_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [FREQ_W-1:0] frequency_mhz;
    logic [PCT_W-1:0]  level_percent;
    logic              sweep_done;
    logic [CH_W-1:0]   best_channel;
    logic [FREQ_W-1:0] best_frequency_mhz;
    logic [PCT_W-1:0]  best_percent;
  } bsp_result_t;

  function automatic logic [FREQ_W-1:0] freq_of(input logic [CH_W-1:0] ch);
    logic [FREQ_W-1:0] f;
    case (ch)
      3'd0:    f = 13'd5705;
      3'd1:    f = 13'd5685;
      3'd2:    f = 13'd5665;
      3'd3:    f = 13'd5645;
      3'd4:    f = 13'd5885;
      3'd5:    f = 13'd5905;
      3'd6:    f = 13'd5925;
      default: f = 13'd5945;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bsp_fifo.sv =====
// Small register-based queue that decouples the sample accumulator from the mapping engine.
// Depends on nothing but its parameters.
`default_nettype none

module bsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bsp_front.sv =====
// Front end: accepts strength samples and sums each group of samples into one reading.
// Depends on bsp_pkg; hands finished sums to the queue.
`default_nettype none

module bsp_front
  import bsp_pkg::*;
#(
  parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF,
  parameter int SUM_W = MV_W + $clog2(SAMPLES_PER_READING)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire logic [MV_W-1:0]  in_sample_mv,
  output logic                  in_full,
  output logic                  q_push,
  output logic [SUM_W-1:0]      q_data,
  input  wire logic             q_full
);

  localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             last_sample, accept;

  // Only the sample that closes a reading needs room in the queue.
  assign last_sample = (cnt_r == CNT_W'(SAMPLES_PER_READING - 1));
  assign in_full     = q_full && last_sample;
  assign accept      = in_push && !in_full;
  assign q_data      = sum_r + SUM_W'(in_sample_mv);
  assign q_push      = accept && last_sample;

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (accept) begin
      if (last_sample) begin
        cnt_nxt = '0;
        sum_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        sum_nxt = q_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bsp_div.sv =====
// Shared iterative restoring divider, one quotient bit per cycle.
// Depends on bsp_pkg; the quotient must fit in QUO_W bits.
`default_nettype none

module bsp_div
  import bsp_pkg::*;
#(
  parameter int DVD_W = NUM_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [MV_W-1:0]  divisor,
  output logic                  done,
  output logic [QUO_W-1:0]      quotient
);

  localparam int DSH_W  = MV_W + QUO_W - 1;
  localparam int STEP_W = $clog2(QUO_W);

  logic [DSH_W-1:0]  rem_r, rem_nxt;
  logic [DSH_W-1:0]  dsh_r, dsh_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge;

  assign ge       = (rem_r >= dsh_r);
  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = DSH_W'(dividend);
      dsh_nxt  = DSH_W'(divisor) << (QUO_W - 1);
      quo_nxt  = '0;
      step_nxt = STEP_W'(QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/bsp_back.sv =====
// Back end: averages a queued sum, maps it to percent, tracks the strongest channel
// and holds the finished result. Depends on bsp_pkg and bsp_div.
`default_nettype none

module bsp_back
  import bsp_pkg::*;
#(
  parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF,
  parameter int SUM_W = MV_W + $clog2(SAMPLES_PER_READING)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [MV_W-1:0]  level_low_mv,
  input  wire logic [MV_W-1:0]  level_high_mv,
  input  wire logic             q_empty,
  input  wire logic [SUM_W-1:0] q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_pop,
  output bsp_result_t           out_result
);

  localparam int DVD_W = NUM_W;

  // The average is floor(sum / SAMPLES_PER_READING), taken as a multiply by a rounded-up
  // reciprocal. With the shift at SUM_W plus the ceiling of log2 of the divisor the result is exact
  // for every sum that fits in SUM_W bits.
  localparam int RCP_SH = SUM_W + $clog2(SAMPLES_PER_READING);
  localparam int RCP_W  = RCP_SH + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_M = RCP_W'(((64'd1 << RCP_SH)
    + 64'(SAMPLES_PER_READING) - 64'd1) / 64'(SAMPLES_PER_READING));

  bsp_state_t       state_r, state_nxt;
  logic [PCT_W-1:0] pct_r, pct_nxt;
  logic [MV_W-1:0]  avg_r, avg_nxt;
  logic [CH_W-1:0]  chan_r, chan_nxt;
  logic [PCT_W-1:0] best_level_r, best_level_nxt;
  logic [CH_W-1:0]  best_index_r, best_index_nxt;
  logic             out_valid_r, out_valid_nxt;
  bsp_result_t      res_r, res_nxt;

  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dividend;
  logic [MV_W-1:0]   div_divisor;
  logic [QUO_W-1:0]  div_quo;
  logic [PROD_W-1:0] avg_prod;
  logic [MV_W-1:0]   avg, diff;
  logic [NUM_W-1:0]  num;
  logic              take_best, last_chan;

  bsp_div #(.DVD_W(DVD_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign avg_prod   = PROD_W'(q_data) * PROD_W'(RCP_M);
  assign avg        = avg_r;
  assign diff       = avg - level_low_mv;
  assign num        = NUM_W'(diff) * NUM_W'(PCT_FULL);
  assign take_best  = (chan_r == '0) || (pct_r > best_level_r);
  assign last_chan  = (chan_r >= CH_W'(CHANNEL_COUNT - 1));
  assign out_valid  = out_valid_r;
  assign out_result = res_r;

  always_comb begin
    state_nxt      = state_r;
    pct_nxt        = pct_r;
    avg_nxt        = avg_r;
    chan_nxt       = chan_r;
    best_level_nxt = best_level_r;
    best_index_nxt = best_index_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    res_nxt        = res_r;
    q_pop          = 1'b0;
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          avg_nxt   = avg_prod[RCP_SH +: MV_W];
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        if (!(level_high_mv > level_low_mv) || (avg <= level_low_mv)) begin
          pct_nxt   = '0;
          state_nxt = ST_EMIT;
        end else if (avg >= level_high_mv) begin
          pct_nxt   = PCT_W'(PCT_FULL);
          state_nxt = ST_EMIT;
        end else begin
          div_start    = 1'b1;
          div_dividend = DVD_W'(num);
          div_divisor  = level_high_mv - level_low_mv;
          state_nxt    = ST_MAP;
        end
      end
      ST_MAP: begin
        if (div_done) begin
          pct_nxt   = div_quo[PCT_W-1:0];
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_pop) begin
          if (take_best) begin
            best_level_nxt = pct_r;
            best_index_nxt = chan_r;
          end
          res_nxt.channel            = chan_r;
          res_nxt.frequency_mhz      = freq_of(chan_r);
          res_nxt.level_percent      = pct_r;
          res_nxt.sweep_done         = last_chan;
          res_nxt.best_channel       = best_index_nxt;
          res_nxt.best_frequency_mhz = freq_of(best_index_nxt);
          res_nxt.best_percent       = best_level_nxt;
          out_valid_nxt              = 1'b1;
          chan_nxt                   = last_chan ? '0 : chan_r + 1'b1;
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      chan_r       <= '0;
      best_level_r <= '0;
      best_index_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chan_r       <= chan_nxt;
      best_level_r <= best_level_nxt;
      best_index_r <= best_index_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pct_r <= pct_nxt;
    avg_r <= avg_nxt;
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/rf_band_scan_peak_finder_core.sv =====
// Band scan peak finder: one strength sample per input transaction; after every
// SAMPLES_PER_READING samples the block averages them, maps the average from the
// level_low_mv..level_high_mv window onto 0..100 percent (truncating, clamped, 0 when
// the window is empty) and emits one result transaction for the current channel, with
// its table frequency, the strongest channel of the sweep so far (first wins on ties)
// and a flag on the sweep's last channel. Samples are taken one per clock while the input
// does not report full. As a finished sum leaves the queue it is averaged by a multiply
// with a constant reciprocal, and the percent mapping then runs through a 12-step
// restoring divider unless the average falls outside the window or the window is empty;
// a two-entry queue holds finished sums, and the input reports full only when the
// sample that closes a reading finds that queue full. A finished result sits in an
// output register until popped, while the next reading is already being worked out. The
// thresholds must be written only while the block is idle. Depends on bsp_pkg, bsp_front,
// bsp_fifo, bsp_div and bsp_back.
`default_nettype none

module rf_band_scan_peak_finder_core
  import bsp_pkg::*;
#(
  parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Configuration write port.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MV_W-1:0]      cfg_wdata,
  // Sample input channel.
  input  wire logic                 in_push,
  input  wire logic [MV_W-1:0]      in_sample_mv,
  output logic                      in_full,
  // Result channel.
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [CH_W-1:0]           out_channel,
  output logic [FREQ_W-1:0]         out_frequency_mhz,
  output logic [PCT_W-1:0]          out_level_percent,
  output logic                      out_sweep_done,
  output logic [CH_W-1:0]           out_best_channel,
  output logic [FREQ_W-1:0]         out_best_frequency_mhz,
  output logic [PCT_W-1:0]          out_best_percent
);

  // Wide enough for SAMPLES_PER_READING samples of full scale.
  localparam int SUM_W = MV_W + $clog2(SAMPLES_PER_READING);

  logic [MV_W-1:0]  level_low_r, level_low_nxt;
  logic [MV_W-1:0]  level_high_r, level_high_nxt;
  logic             q_push, q_full, q_pop, q_empty;
  logic [SUM_W-1:0] q_wdata, q_rdata;
  logic             out_valid;
  bsp_result_t      result;

  // Threshold registers.
  always_comb begin
    level_low_nxt  = level_low_r;
    level_high_nxt = level_high_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LEVEL_LOW:  level_low_nxt  = cfg_wdata;
        REG_LEVEL_HIGH: level_high_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_low_r  <= LEVEL_LOW_RST;
      level_high_r <= LEVEL_HIGH_RST;
    end else begin
      level_low_r  <= level_low_nxt;
      level_high_r <= level_high_nxt;
    end
  end

  bsp_front #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING),
    .SUM_W               (SUM_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_sample_mv (in_sample_mv),
    .in_full      (in_full),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  bsp_fifo #(
    .WIDTH (SUM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  bsp_back #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING),
    .SUM_W               (SUM_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .level_low_mv  (level_low_r),
    .level_high_mv (level_high_r),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_pop       (out_pop),
    .out_result    (result)
  );

  // The result register drives the output ports directly.
  assign out_empty              = !out_valid;
  assign out_channel            = result.channel;
  assign out_frequency_mhz      = result.frequency_mhz;
  assign out_level_percent      = result.level_percent;
  assign out_sweep_done         = result.sweep_done;
  assign out_best_channel       = result.best_channel;
  assign out_best_frequency_mhz = result.best_frequency_mhz;
  assign out_best_percent       = result.best_percent;

endmodule

`default_nettype wire

// ===== hdl/bsp_checker.sv =====
// Port-level checks of the band scan peak finder, attached to the top level by bind.
// Depends on bsp_pkg and rf_band_scan_peak_finder_core.
`default_nettype none

module bsp_checker
  import bsp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_empty,
  input wire logic              out_pop,
  input wire logic [CH_W-1:0]   out_channel,
  input wire logic [PCT_W-1:0]  out_level_percent,
  input wire logic              out_sweep_done,
  input wire logic [PCT_W-1:0]  out_best_percent
);

  // Reset leaves no result transaction behind.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A waiting result holds until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_channel)
      && $stable(out_level_percent)))
    else $error("waiting result changed before pop");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_level_percent <= PCT_W'(PCT_FULL)))
    else $error("percent above full scale");

  // The strongest so far can never be weaker than the channel just measured.
  a_best_ge: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_best_percent >= out_level_percent))
    else $error("best percent below current percent");

  a_sweep_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_sweep_done == (out_channel == CH_W'(CHANNEL_COUNT - 1))))
    else $error("sweep_done does not match the last channel");

endmodule

bind rf_band_scan_peak_finder_core bsp_checker u_bsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_channel       (out_channel),
  .out_level_percent (out_level_percent),
  .out_sweep_done    (out_sweep_done),
  .out_best_percent  (out_best_percent)
);

`default_nettype wire
